// ----- rtl/ruaie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruaie_pkg
// shared types and constants for the rectangle union area block
// ----------------------------------------------------------------------------
package ruaie_pkg;

  // modulus of the reported area
  localparam int unsigned RES_W = 30;
  localparam logic [RES_W-1:0] AREA_MOD = 30'd1000000007;

  // tag that travels with each subset down the cell chain
  typedef struct packed {
    logic vld;  // a subset occupies this slot
    logic odd;  // parity of the members taken so far
    logic fin;  // last subset of the set
  } cell_tag_t;

  // status of the serial modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

endpackage

// ----- rtl/ruaie_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruaie_cell
// one stored rectangle; narrows the passing intersection when selected
// ----------------------------------------------------------------------------
module ruaie_cell #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RECTS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic signed [COORD_BITS-1:0]  wr_lx,
  input  logic signed [COORD_BITS-1:0]  wr_ly,
  input  logic signed [COORD_BITS-1:0]  wr_hx,
  input  logic signed [COORD_BITS-1:0]  wr_hy,
  input  ruaie_pkg::cell_tag_t          tag_in,
  input  logic [MAX_RECTS-1:0]          sel_in,
  input  logic signed [COORD_BITS-1:0]  lx_in,
  input  logic signed [COORD_BITS-1:0]  ly_in,
  input  logic signed [COORD_BITS-1:0]  hx_in,
  input  logic signed [COORD_BITS-1:0]  hy_in,
  output ruaie_pkg::cell_tag_t          tag_out,
  output logic [MAX_RECTS-1:0]          sel_out,
  output logic signed [COORD_BITS-1:0]  lx_out,
  output logic signed [COORD_BITS-1:0]  ly_out,
  output logic signed [COORD_BITS-1:0]  hx_out,
  output logic signed [COORD_BITS-1:0]  hy_out
);
  import ruaie_pkg::*;

  logic signed [COORD_BITS-1:0] r_lx, r_ly, r_hx, r_hy;
  logic                         hit;
  logic signed [COORD_BITS-1:0] lx_next, ly_next, hx_next, hy_next;
  cell_tag_t                    tag_next;

  always_ff @(posedge clk) begin
    if (we) begin
      r_lx <= wr_lx;
      r_ly <= wr_ly;
      r_hx <= wr_hx;
      r_hy <= wr_hy;
    end
  end

  // this cell's rectangle sits at bit 0 of the shifted subset
  assign hit = sel_in[0];

  always_comb begin
    lx_next = (hit && (r_lx > lx_in)) ? r_lx : lx_in;
    ly_next = (hit && (r_ly > ly_in)) ? r_ly : ly_in;
    hx_next = (hit && (r_hx < hx_in)) ? r_hx : hx_in;
    hy_next = (hit && (r_hy < hy_in)) ? r_hy : hy_in;
    tag_next     = tag_in;
    tag_next.odd = tag_in.odd ^ hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_next;
    end
    sel_out <= sel_in >> 1;
    lx_out  <= lx_next;
    ly_out  <= ly_next;
    hx_out  <= hx_next;
    hy_out  <= hy_next;
  end

endmodule

// ----- rtl/ruaie_area.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruaie_area
// area of each intersection and signed running sum, three stages
// ----------------------------------------------------------------------------
module ruaie_area #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RECTS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  ruaie_pkg::cell_tag_t                 tag_in,
  input  logic signed [COORD_BITS-1:0]         lx_in,
  input  logic signed [COORD_BITS-1:0]         ly_in,
  input  logic signed [COORD_BITS-1:0]         hx_in,
  input  logic signed [COORD_BITS-1:0]         hy_in,
  output logic [2*COORD_BITS+MAX_RECTS:0]      acc,
  output logic                                 done
);
  import ruaie_pkg::*;

  localparam int ACC_W = 2*COORD_BITS + MAX_RECTS + 1;

  logic signed [COORD_BITS:0]  dx, dy;
  logic                        ok;
  cell_tag_t                   tag1, tag2;
  logic                        ok1, ok2;
  logic [COORD_BITS-1:0]       w1, h1;
  logic [2*COORD_BITS-1:0]     prod, p2;
  logic [ACC_W-1:0]            term;

  assign ok = (lx_in <= hx_in) && (ly_in <= hy_in);
  assign dx = {hx_in[COORD_BITS-1], hx_in} - {lx_in[COORD_BITS-1], lx_in};
  assign dy = {hy_in[COORD_BITS-1], hy_in} - {ly_in[COORD_BITS-1], ly_in};

  assign prod = w1 * h1;
  assign term = ok2 ? ACC_W'(p2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      done <= 1'b0;
      acc  <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      done <= tag2.vld && tag2.fin;
      if (clear) begin
        acc <= '0;
      end else if (tag2.vld) begin
        // odd subsets add, even subsets take away
        acc <= tag2.odd ? (acc + term) : (acc - term);
      end
    end
    ok1 <= ok;
    w1  <= dx[COORD_BITS-1:0];
    h1  <= dy[COORD_BITS-1:0];
    ok2 <= ok1;
    p2  <= prod;
  end

endmodule

// ----- rtl/ruaie_modred.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruaie_modred
// reduction of the final sum modulo the area modulus by compare and subtract
// ----------------------------------------------------------------------------
module ruaie_modred #(
  parameter int IN_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [IN_W-1:0]        value,
  output ruaie_pkg::red_stat_t   stat,
  output logic [29:0]            res
);
  import ruaie_pkg::*;

  localparam int WORK_W = (IN_W > RES_W) ? IN_W : RES_W;
  localparam int STEPS  = (IN_W > RES_W) ? (IN_W - RES_W + 1) : 1;
  localparam int CNT_W  = $clog2(STEPS + 1);
  // largest multiple of the modulus tried first, halved each step
  localparam logic [WORK_W-1:0] MOD_TOP = WORK_W'(AREA_MOD) << (STEPS - 1);

  logic [WORK_W-1:0] rem;
  logic [WORK_W-1:0] dm;
  logic [CNT_W-1:0]  cnt;

  assign res = rem[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      if (start) begin
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        rem       <= WORK_W'(value);
        dm        <= MOD_TOP;
        cnt       <= CNT_W'(STEPS);
      end else if (stat.busy) begin
        if (rem >= dm) begin
          rem <= rem - dm;
        end
        dm        <= dm >> 1;
        cnt       <= cnt - 1'b1;
        stat.busy <= (cnt != CNT_W'(1));
        stat.done <= (cnt == CNT_W'(1));
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/rectangle_union_area_incl_excl_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_union_area_incl_excl_top
// union area of a set of rectangles by inclusion-exclusion, modulo 1e9+7
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one rectangle per beat; s_tlast closes the set. up to
//   MAX_RECTS rectangles are kept, one per cell; further ones are dropped
//   and reported through m_tuser with the result of that set.
//   while loading, a beat is taken every cycle and gives no result.
//   the closing beat starts the sweep: every non-empty subset of the n held
//   rectangles enters the cell chain, one per cycle; the last subset then
//   passes through the rest of the chain, 3 area stages and
//   max(1, 2*COORD_BITS-29) compare-and-subtract steps for the modulo
//   (3 with 16-bit corners) before the hand-over to the output register.
//   s_tready is low from the closing beat until the result is registered.
//   the result waits in the output register; a stalled receiver does not
//   hold up loading of the next set, but if its result is ready while the
//   older one still waits, the block holds with s_tready low until then.
//   rst clears the count, the overflow flag and m_tvalid, and raises s_tready;
//   rectangles need no clearing as only the first n of a set are read.
// ----------------------------------------------------------------------------
module rectangle_union_area_incl_excl_top #(
  parameter int MAX_RECTS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_x, bottom_y, right_x, top_y
  input  logic        s_tlast,   // last_rect
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // union_area_mod, zero pad
  output logic        m_tuser    // overflowed
);
  import ruaie_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int ACC_W = 2*COORD_BITS + MAX_RECTS + 1;

  typedef enum logic [2:0] {
    S_LOAD,   // taking rectangles
    S_RUN,    // issuing subsets into the chain
    S_WAIT,   // chain and area stages draining
    S_RED,    // modulo steps
    S_OUT     // waiting for the output register
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             count;
  logic                         ovf;
  logic [MAX_RECTS-1:0]         subset;
  logic [MAX_RECTS:0]           span;
  logic [MAX_RECTS-1:0]         mask;
  logic                         fin;
  logic                         s_acc;
  logic                         full;

  logic signed [COORD_BITS-1:0] wr_lx, wr_ly, wr_hx, wr_hy;

  // chain taps, slot 0 is the head
  cell_tag_t                    tag_c [0:MAX_RECTS];
  logic [MAX_RECTS-1:0]         sel_c [0:MAX_RECTS];
  logic signed [COORD_BITS-1:0] lx_c  [0:MAX_RECTS];
  logic signed [COORD_BITS-1:0] ly_c  [0:MAX_RECTS];
  logic signed [COORD_BITS-1:0] hx_c  [0:MAX_RECTS];
  logic signed [COORD_BITS-1:0] hy_c  [0:MAX_RECTS];

  logic [ACC_W-1:0]             acc;
  logic                         area_done;
  red_stat_t                    red_stat;
  logic [RES_W-1:0]             red_res;

  assign s_tready = (state == S_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(MAX_RECTS));

  // corners keep COORD_BITS bits of each field, read as two's complement
  assign wr_lx = COORD_BITS'(s_tdata[15:0]);
  assign wr_ly = COORD_BITS'(s_tdata[31:16]);
  assign wr_hx = COORD_BITS'(s_tdata[47:32]);
  assign wr_hy = COORD_BITS'(s_tdata[63:48]);

  // subsets run from 1 up to all n held rectangles
  assign span = ({{MAX_RECTS{1'b0}}, 1'b1} << count) - 1'b1;
  assign mask = span[MAX_RECTS-1:0];
  assign fin  = (subset == mask);

  // head of the chain: widest possible box, no members yet
  assign tag_c[0] = '{vld: (state == S_RUN), odd: 1'b0, fin: fin};
  assign sel_c[0] = subset;
  assign lx_c[0]  = {1'b1, {(COORD_BITS-1){1'b0}}};
  assign ly_c[0]  = {1'b1, {(COORD_BITS-1){1'b0}}};
  assign hx_c[0]  = {1'b0, {(COORD_BITS-1){1'b1}}};
  assign hy_c[0]  = {1'b0, {(COORD_BITS-1){1'b1}}};

  for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
    ruaie_cell #(
      .COORD_BITS (COORD_BITS),
      .MAX_RECTS  (MAX_RECTS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .we      (s_acc && (count == CNT_W'(k))),
      .wr_lx   (wr_lx),
      .wr_ly   (wr_ly),
      .wr_hx   (wr_hx),
      .wr_hy   (wr_hy),
      .tag_in  (tag_c[k]),
      .sel_in  (sel_c[k]),
      .lx_in   (lx_c[k]),
      .ly_in   (ly_c[k]),
      .hx_in   (hx_c[k]),
      .hy_in   (hy_c[k]),
      .tag_out (tag_c[k+1]),
      .sel_out (sel_c[k+1]),
      .lx_out  (lx_c[k+1]),
      .ly_out  (ly_c[k+1]),
      .hx_out  (hx_c[k+1]),
      .hy_out  (hy_c[k+1])
    );
  end

  ruaie_area #(
    .COORD_BITS (COORD_BITS),
    .MAX_RECTS  (MAX_RECTS)
  ) u_area (
    .clk    (clk),
    .rst    (rst),
    .clear  (s_acc && s_tlast),
    .tag_in (tag_c[MAX_RECTS]),
    .lx_in  (lx_c[MAX_RECTS]),
    .ly_in  (ly_c[MAX_RECTS]),
    .hx_in  (hx_c[MAX_RECTS]),
    .hy_in  (hy_c[MAX_RECTS]),
    .acc    (acc),
    .done   (area_done)
  );

  // the union area is never negative and stays below 2^(2*COORD_BITS),
  // so the low bits of the wrapped sum hold it exactly
  ruaie_modred #(
    .IN_W (2*COORD_BITS)
  ) u_modred (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_WAIT) && area_done),
    .value (acc[2*COORD_BITS-1:0]),
    .stat  (red_stat),
    .res   (red_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      subset   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // in S_OUT a taken beat is replaced below
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (s_acc) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (s_tlast) begin
              subset <= {{(MAX_RECTS-1){1'b0}}, 1'b1};
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          subset <= subset + 1'b1;
          if (fin) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (area_done) begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (red_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // output register free or emptying this cycle
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, red_res};
            m_tuser  <= ovf;
            count    <= '0;
            ovf      <= 1'b0;
            state    <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ruaie_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruaie_checker
// port-level checks of the rectangle union area block
// ----------------------------------------------------------------------------
module ruaie_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);
  import ruaie_pkg::*;

  // result is a true residue and the pad bits stay clear
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:30] == 2'b00) && (m_tdata[29:0] < AREA_MOD))
    else $error("result out of residue range");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // closing beat stops intake while the sweep runs
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken after closing beat");

  // a new result only comes out of the sweep, never during loading
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result raised while loading");

endmodule

bind rectangle_union_area_incl_excl_top ruaie_checker u_ruaie_checker (.*);
